FILE: src/pms_pkg.sv
// Shared types and constants for the permuted matrix store.
// No dependencies; all other files but pms_ram import this package.
package pms_pkg;

    localparam int MAX_DIM    = 64;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int ELEM_DEPTH = MAX_DIM * MAX_DIM;
    localparam int CNT_W      = 7;
    localparam int DATA_W     = 32;
    localparam int FUNC_W     = 3;
    localparam int CFG_IDX_W  = 2;

    localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE     = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SWAP_ROWS = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SWAP_COLS = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TRANSPOSE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

    // Request from the sequencer to the map store
    typedef struct packed {
        logic [IDX_W-1:0] raddr0;
        logic [IDX_W-1:0] raddr1;
        logic             we;
        logic             wsel;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
        logic             reset_maps;
    } map_req_t;

    // Map entries, in the cycle after the read addresses were presented
    typedef struct packed {
        logic [IDX_W-1:0] data0;
        logic [IDX_W-1:0] data1;
    } map_rsp_t;

endpackage

FILE: src/permuted_matrix_store_unit.sv
// Top level of the permuted matrix store: sequencer, element RAM and clearing pass.
// Depends on pms_pkg, pms_ram and pms_map_store.

// A 64 x 64 matrix of 32-bit patterns reached through a row map and a column
// map, one transaction in and one result transaction out per item; the next
// item is accepted only once the sequencer is back in idle. Out-of-range items,
// transposes, unused codes and self-swaps go straight to the result state; a
// write passes through the registered map RAM read, and a read through it and
// then the registered element RAM read; a swap does two reads and two writes
// through the single port pair of one map RAM. A transpose only flips which
// physical map serves as the row map, so it costs no copying. After reset and
// after every write of a dimension register the element RAM is zeroed by a
// clearing pass, one entry per cycle; input stalls during the pass while the
// configuration port stays open. The maps return to identity at once through
// per-entry valid bits. One finished result may wait in the output register
// while the next item is accepted and worked on.
module permuted_matrix_store_unit
    import pms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    // input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [FUNC_W-1:0]    func,
    input  logic [CNT_W-1:0]     first_index,
    input  logic [CNT_W-1:0]     second_index,
    input  logic [DATA_W-1:0]    write_value,
    // output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DATA_W-1:0]    read_value,
    output logic                 status
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ACC    = 3'd1;
    localparam logic [2:0] ST_ACC_RD = 3'd2;
    localparam logic [2:0] ST_SW_A   = 3'd3;
    localparam logic [2:0] ST_SW_B   = 3'd4;
    localparam logic [2:0] ST_SW_W   = 3'd5;
    localparam logic [2:0] ST_RESULT = 3'd6;

    // control state
    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  dim_rows_reg, dim_rows_next;
    logic [CNT_W-1:0]  dim_cols_reg, dim_cols_next;
    logic              transposed_reg, transposed_next;
    logic              clear_active_reg, clear_active_next;
    logic [ADDR_W-1:0] clear_addr_reg, clear_addr_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [IDX_W-1:0]  a_reg, a_next;
    logic [IDX_W-1:0]  b_reg, b_next;
    logic              sel_reg, sel_next;
    logic [DATA_W-1:0] wv_reg, wv_next;
    logic [IDX_W-1:0]  tmp_reg, tmp_next;
    logic [DATA_W-1:0] res_value_reg, res_value_next;
    logic              res_status_reg, res_status_next;
    logic [DATA_W-1:0] read_value_reg, read_value_next;
    logic              status_reg, status_next;

    logic              in_accept;
    logic              cfg_hit;
    logic [CNT_W-1:0]  rows_raw, cols_raw, rows, cols;
    logic              acc_oob, row_oob, col_oob;
    logic [IDX_W-1:0]  p_idx, q_idx, sel_data;
    logic [ADDR_W-1:0] elem_addr;
    logic              elem_we;
    logic [ADDR_W-1:0] elem_waddr;
    logic [DATA_W-1:0] elem_wdata;
    logic [DATA_W-1:0] elem_rdata;
    logic              out_free;
    map_req_t          map_req;
    map_rsp_t          map_rsp;

    assign in_stall  = clear_active_reg | (state_reg != ST_IDLE);
    assign in_accept = in_valid & ~in_stall;
    assign cfg_hit   = cfg_write_en &
                       ((cfg_index == REG_ROW_COUNT) || (cfg_index == REG_COL_COUNT));
    assign out_free  = ~out_valid_reg | ~out_stall;

    // Current dimensions, saturated to the physical size
    assign rows_raw = transposed_reg ? dim_cols_reg : dim_rows_reg;
    assign cols_raw = transposed_reg ? dim_rows_reg : dim_cols_reg;
    assign rows     = (rows_raw > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : rows_raw;
    assign cols     = (cols_raw > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : cols_raw;

    assign acc_oob = (first_index >= rows) || (second_index >= cols);
    assign row_oob = (first_index >= rows) || (second_index >= rows);
    assign col_oob = (first_index >= cols) || (second_index >= cols);

    // Physical map transposed_reg serves rows, the other one serves columns
    assign p_idx     = transposed_reg ? map_rsp.data1 : map_rsp.data0;
    assign q_idx     = transposed_reg ? map_rsp.data0 : map_rsp.data1;
    assign elem_addr = transposed_reg ? {q_idx, p_idx} : {p_idx, q_idx};
    assign sel_data  = sel_reg ? map_rsp.data1 : map_rsp.data0;

    // Map store requests
    always_comb
    begin
        map_req            = '0;
        map_req.reset_maps = cfg_hit;
        map_req.wsel       = sel_reg;
        if (state_reg == ST_SW_A)
        begin
            map_req.raddr0 = b_reg;
            map_req.raddr1 = b_reg;
        end
        else if ((func == FUNC_READ) || (func == FUNC_WRITE))
        begin
            map_req.raddr0 = transposed_reg ? second_index[IDX_W-1:0]
                                            : first_index[IDX_W-1:0];
            map_req.raddr1 = transposed_reg ? first_index[IDX_W-1:0]
                                            : second_index[IDX_W-1:0];
        end
        else
        begin
            map_req.raddr0 = first_index[IDX_W-1:0];
            map_req.raddr1 = first_index[IDX_W-1:0];
        end
        if (state_reg == ST_SW_B)
        begin
            map_req.we    = 1'b1;
            map_req.waddr = a_reg;
            map_req.wdata = sel_data;
        end
        else if (state_reg == ST_SW_W)
        begin
            map_req.we    = 1'b1;
            map_req.waddr = b_reg;
            map_req.wdata = tmp_reg;
        end
    end

    pms_map_store u_maps (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (map_req),
        .rsp   (map_rsp)
    );

    // Element RAM: the clearing pass owns the write port while it runs
    always_comb
    begin
        if (clear_active_reg)
        begin
            elem_we    = 1'b1;
            elem_waddr = clear_addr_reg;
            elem_wdata = '0;
        end
        else
        begin
            elem_we    = (state_reg == ST_ACC) && (func_reg == FUNC_WRITE);
            elem_waddr = elem_addr;
            elem_wdata = wv_reg;
        end
    end

    pms_ram #(.WIDTH(DATA_W), .DEPTH(ELEM_DEPTH)) u_elements (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (elem_wdata),
        .raddr (elem_addr),
        .rdata (elem_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        dim_rows_next     = dim_rows_reg;
        dim_cols_next     = dim_cols_reg;
        transposed_next   = transposed_reg;
        clear_active_next = clear_active_reg;
        clear_addr_next   = clear_addr_reg;
        out_valid_next    = out_valid_reg & out_stall;
        func_next         = func_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        sel_next          = sel_reg;
        wv_next           = wv_reg;
        tmp_next          = tmp_reg;
        res_value_next    = res_value_reg;
        res_status_next   = res_status_reg;
        read_value_next   = read_value_reg;
        status_next       = status_reg;

        // advance the clearing pass
        if (clear_active_reg)
        begin
            clear_addr_next = clear_addr_reg + ADDR_W'(1);
            if (clear_addr_reg == ADDR_W'(ELEM_DEPTH - 1))
            begin
                clear_active_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    func_next       = func;
                    a_next          = first_index[IDX_W-1:0];
                    b_next          = second_index[IDX_W-1:0];
                    wv_next         = write_value;
                    sel_next        = (func == FUNC_SWAP_ROWS) ? transposed_reg
                                                               : ~transposed_reg;
                    res_value_next  = '0;
                    res_status_next = 1'b0;
                    state_next      = ST_RESULT;
                    case (func) inside
                        FUNC_READ, FUNC_WRITE:
                        begin
                            if (acc_oob)
                            begin
                                res_status_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_ACC;
                            end
                        end
                        FUNC_SWAP_ROWS, FUNC_SWAP_COLS:
                        begin
                            if ((func == FUNC_SWAP_ROWS) ? row_oob : col_oob)
                            begin
                                res_status_next = 1'b1;
                            end
                            else if (first_index != second_index)
                            begin
                                state_next = ST_SW_A;
                            end
                        end
                        FUNC_TRANSPOSE:
                        begin
                            transposed_next = ~transposed_reg;
                        end
                        default:
                        begin
                            // unused code: plain done result
                        end
                    endcase
                end
            end
            ST_ACC:
            begin
                state_next = (func_reg == FUNC_READ) ? ST_ACC_RD : ST_RESULT;
            end
            ST_ACC_RD:
            begin
                res_value_next = elem_rdata;
                state_next     = ST_RESULT;
            end
            ST_SW_A:
            begin
                // hold the entry at the first index, fetch the second
                tmp_next   = sel_data;
                state_next = ST_SW_B;
            end
            ST_SW_B:
            begin
                state_next = ST_SW_W;
            end
            ST_SW_W:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    read_value_next = res_value_reg;
                    status_next     = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a dimension write starts a fresh matrix
        if (cfg_hit)
        begin
            if (cfg_index == REG_ROW_COUNT)
            begin
                dim_rows_next = cfg_data;
            end
            else
            begin
                dim_cols_next = cfg_data;
            end
            transposed_next   = 1'b0;
            clear_active_next = 1'b1;
            clear_addr_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            dim_rows_reg     <= '0;
            dim_cols_reg     <= '0;
            transposed_reg   <= 1'b0;
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            dim_rows_reg     <= dim_rows_next;
            dim_cols_reg     <= dim_cols_next;
            transposed_reg   <= transposed_next;
            clear_active_reg <= clear_active_next;
            clear_addr_reg   <= clear_addr_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        sel_reg        <= sel_next;
        wv_reg         <= wv_next;
        tmp_reg        <= tmp_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        read_value_reg <= read_value_next;
        status_reg     <= status_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

    // Checks

    // an out-of-range result never carries data
    a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (read_value == '0))
        else $error("out-of-range result with nonzero read_value");

    // every accepted transaction leaves idle on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != ST_IDLE))
        else $error("accepted transaction did not start work");

    // element read data is only captured right after a read access
    a_read_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC_RD) |-> ($past(state_reg) == ST_ACC &&
                                      $past(func_reg) == FUNC_READ))
        else $error("element read capture out of sequence");

    // no item enters while the element RAM is being cleared
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        clear_active_reg |-> !in_accept)
        else $error("transaction accepted during clearing pass");

endmodule

FILE: src/pms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/pms_map_store.sv
// Two physical index maps, each a RAM with per-entry valid bits.
// Depends on pms_pkg and pms_ram; an entry not yet written reads as its own index.
module pms_map_store
    import pms_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  map_req_t req,
    output map_rsp_t rsp
);

    logic [MAX_DIM-1:0] valid0_reg, valid1_reg;
    logic [MAX_DIM-1:0] valid0_next, valid1_next;
    logic [IDX_W-1:0]   raddr0_reg, raddr1_reg;
    logic [IDX_W-1:0]   rdata0, rdata1;

    pms_ram #(.WIDTH(IDX_W), .DEPTH(MAX_DIM)) u_map0 (
        .clk   (clk),
        .we    (req.we & ~req.wsel),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .raddr (req.raddr0),
        .rdata (rdata0)
    );

    pms_ram #(.WIDTH(IDX_W), .DEPTH(MAX_DIM)) u_map1 (
        .clk   (clk),
        .we    (req.we & req.wsel),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .raddr (req.raddr1),
        .rdata (rdata1)
    );

    always_comb
    begin
        valid0_next = valid0_reg;
        valid1_next = valid1_reg;
        if (req.reset_maps)
        begin
            valid0_next = '0;
            valid1_next = '0;
        end
        else if (req.we)
        begin
            if (req.wsel)
            begin
                valid1_next[req.waddr] = 1'b1;
            end
            else
            begin
                valid0_next[req.waddr] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= '0;
            valid1_reg <= '0;
        end
        else
        begin
            valid0_reg <= valid0_next;
            valid1_reg <= valid1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raddr0_reg <= req.raddr0;
        raddr1_reg <= req.raddr1;
    end

    assign rsp.data0 = valid0_reg[raddr0_reg] ? rdata0 : raddr0_reg;
    assign rsp.data1 = valid1_reg[raddr1_reg] ? rdata1 : raddr1_reg;

endmodule

FILE: tb/sv/matrix_access_checker.sv
// Checker for the permuted matrix store: watches the configuration port and both channels.
// Predicts every result transaction and compares it field by field; depends on pms_pkg.
module matrix_access_checker
    import pms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [FUNC_W-1:0]    func,
    input  logic [CNT_W-1:0]     first_index,
    input  logic [CNT_W-1:0]     second_index,
    input  logic [DATA_W-1:0]    write_value,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [DATA_W-1:0]    read_value,
    input  logic                 status,
    output int unsigned          mismatch_count,
    output int unsigned          answers_pending
);

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              status;
    } access_answer_t;

    logic [DATA_W-1:0] elem_mem [ELEM_DEPTH];
    logic [IDX_W-1:0]  row_perm [MAX_DIM];
    logic [IDX_W-1:0]  col_perm [MAX_DIM];
    logic              flipped;
    logic [CNT_W-1:0]  rows_cfg;
    logic [CNT_W-1:0]  cols_cfg;
    access_answer_t    predicted_answers [$];
    int unsigned       answer_index;

    function automatic logic [CNT_W-1:0] clamp_dim(input logic [CNT_W-1:0] d);
        return (d > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : d;
    endfunction

    // Zero the store, restore identity maps, drop the transpose.
    function automatic void start_fresh_matrix();
        for (int i = 0; i < ELEM_DEPTH; i++)
            elem_mem[i] = '0;
        for (int i = 0; i < MAX_DIM; i++) begin
            row_perm[i] = IDX_W'(i);
            col_perm[i] = IDX_W'(i);
        end
        flipped = 1'b0;
    endfunction

    function automatic access_answer_t predict_access(
        input logic [FUNC_W-1:0] f,
        input logic [CNT_W-1:0]  a,
        input logic [CNT_W-1:0]  b,
        input logic [DATA_W-1:0] wv
    );
        access_answer_t    answer;
        logic [CNT_W-1:0]  n_rows;
        logic [CNT_W-1:0]  n_cols;
        logic [ADDR_W-1:0] addr;
        logic [IDX_W-1:0]  held;
        answer = '0;
        n_rows = clamp_dim(flipped ? cols_cfg : rows_cfg);
        n_cols = clamp_dim(flipped ? rows_cfg : cols_cfg);
        case (f)
            FUNC_READ, FUNC_WRITE: begin
                if (a >= n_rows || b >= n_cols) begin
                    answer.status = 1'b1;
                end else begin
                    // a transpose swaps which map feeds the high address half
                    addr = flipped ? {col_perm[b[IDX_W-1:0]], row_perm[a[IDX_W-1:0]]}
                                   : {row_perm[a[IDX_W-1:0]], col_perm[b[IDX_W-1:0]]};
                    if (f == FUNC_READ)
                        answer.value = elem_mem[addr];
                    else
                        elem_mem[addr] = wv;
                end
            end
            FUNC_SWAP_ROWS: begin
                if (a >= n_rows || b >= n_rows) begin
                    answer.status = 1'b1;
                end else begin
                    held = row_perm[a[IDX_W-1:0]];
                    row_perm[a[IDX_W-1:0]] = row_perm[b[IDX_W-1:0]];
                    row_perm[b[IDX_W-1:0]] = held;
                end
            end
            FUNC_SWAP_COLS: begin
                if (a >= n_cols || b >= n_cols) begin
                    answer.status = 1'b1;
                end else begin
                    held = col_perm[a[IDX_W-1:0]];
                    col_perm[a[IDX_W-1:0]] = col_perm[b[IDX_W-1:0]];
                    col_perm[b[IDX_W-1:0]] = held;
                end
            end
            FUNC_TRANSPOSE: begin
                for (int i = 0; i < MAX_DIM; i++) begin
                    held = row_perm[i];
                    row_perm[i] = col_perm[i];
                    col_perm[i] = held;
                end
                flipped = !flipped;
            end
            default: ;
        endcase
        return answer;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $time, answer_index, msg);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        access_answer_t got;
        access_answer_t want;
        if (!rst_n) begin
            rows_cfg = '0;
            cols_cfg = '0;
            start_fresh_matrix();
            predicted_answers.delete();
            answer_index = 0;
            mismatch_count = 0;
            answers_pending <= 0;
        end else begin
            if (cfg_write_en) begin
                case (cfg_index)
                    REG_ROW_COUNT: begin
                        rows_cfg = cfg_data;
                        start_fresh_matrix();
                    end
                    REG_COL_COUNT: begin
                        cols_cfg = cfg_data;
                        start_fresh_matrix();
                    end
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predicted_answers.push_back(
                    predict_access(func, first_index, second_index, write_value));
            if (out_valid && !out_stall) begin
                got.value  = read_value;
                got.status = status;
                if (predicted_answers.size() == 0) begin
                    report_mismatch($sformatf("no result awaited, got read_value %h status %b",
                                              got.value, got.status));
                end else begin
                    want = predicted_answers.pop_front();
                    if (got.value !== want.value)
                        report_mismatch($sformatf("read_value %h, expected %h",
                                                  got.value, want.value));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %b, expected %b",
                                                  got.status, want.status));
                end
                answer_index++;
            end
            answers_pending <= predicted_answers.size();
        end
    end

endmodule

FILE: tb/sv/permuted_matrix_store_unit_tb.sv
// Top of the permuted matrix store testbench: clock, reset, stimulus and verdict.
// Depends on pms_pkg, permuted_matrix_store_unit and matrix_access_checker.
module permuted_matrix_store_unit_tb;
    import pms_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 6;
    localparam int GAP_MAX         = 10;
    // leave some margin for the slowest item after the queue drains
    localparam int DRAIN_CYCLES    = 12;
    // covers a clearing pass per register write plus every item at its slowest
    localparam int CYCLE_LIMIT     = 600000;
    localparam int PHASE_ITEMS     = 150;
    localparam int ZERO_DIM_ITEMS  = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int N_PHASES        = 12;
    localparam int INDEX_TOP       = 2 ** CNT_W - 1;

    localparam logic [FUNC_W-1:0]    FUNC_UNUSED_FIRST = FUNC_TRANSPOSE + 1'b1;
    localparam logic [FUNC_W-1:0]    FUNC_UNUSED_LAST  = {FUNC_W{1'b1}};
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST   = REG_COL_COUNT + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST    = {CFG_IDX_W{1'b1}};

    // every input starts at a known value
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CNT_W-1:0]     cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [FUNC_W-1:0]    func         = '0;
    logic [CNT_W-1:0]     first_index  = '0;
    logic [CNT_W-1:0]     second_index = '0;
    logic [DATA_W-1:0]    write_value  = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [DATA_W-1:0]    read_value;
    logic                 status;

    int unsigned mismatch_count;
    int unsigned answers_pending;
    int unsigned cycle_count      = 0;
    int unsigned tx_gap_max       = GAP_MAX;
    int unsigned rx_gap_max       = GAP_MAX;
    int unsigned hold_off_request = 0;
    int unsigned index_span       = 1;

    // dimension pairs per phase: empty, half empty, full, saturated, tiny, odd shapes
    int unsigned phase_rows [N_PHASES] = '{0, 0, 6, 64, 127, 65, 1, 2, 8, 5, 4, 3};
    int unsigned phase_cols [N_PHASES] = '{0, 5, 4, 64, 127, 3, 1, 7, 8, 2, 4, 3};

    always #(CLK_HALF) clk = ~clk;

    permuted_matrix_store_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .first_index  (first_index),
        .second_index (second_index),
        .write_value  (write_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_value   (read_value),
        .status       (status)
    );

    matrix_access_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .first_index     (first_index),
        .second_index    (second_index),
        .write_value     (write_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .read_value      (read_value),
        .status          (status),
        .mismatch_count  (mismatch_count),
        .answers_pending (answers_pending)
    );

    // Watchdog: stop a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: draw a stall length per transaction, then take one result.
    // A pending hold-off request overrides the draw once, so the block backs up.
    initial begin : receiver
        int unsigned hold;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_off_request != 0) begin
                hold = hold_off_request;
                hold_off_request = 0;
            end else begin
                hold = $urandom_range(0, rx_gap_max);
            end
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Write one register; both edges keep each signal to one update per step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid and wait until every predicted result has come back, then let
    // the block settle before anything touches the configuration.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (answers_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Offer one transaction after a random gap and hold it until accepted.
    // Valid stays high across back-to-back transactions.
    task automatic send_access(
        input logic [FUNC_W-1:0] f,
        input logic [CNT_W-1:0]  a,
        input logic [CNT_W-1:0]  b,
        input logic [DATA_W-1:0] wv
    );
        int unsigned gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        first_index  <= a;
        second_index <= b;
        write_value  <= wv;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Mostly accesses inside the current span so writes get read back; one index
    // in ten spans the whole field to hit the out-of-range paths.
    task automatic send_random_access();
        int unsigned       pick;
        logic [FUNC_W-1:0] f;
        logic [CNT_W-1:0]  a;
        logic [CNT_W-1:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            f = FUNC_READ;
        else if (pick < 65)
            f = FUNC_WRITE;
        else if (pick < 77)
            f = FUNC_SWAP_ROWS;
        else if (pick < 89)
            f = FUNC_SWAP_COLS;
        else if (pick < 96)
            f = FUNC_TRANSPOSE;
        else
            f = FUNC_W'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
        a = CNT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, INDEX_TOP)
                                               : $urandom_range(0, index_span - 1));
        b = CNT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, INDEX_TOP)
                                               : $urandom_range(0, index_span - 1));
        send_access(f, a, b, $urandom());
    endtask

    // Pick the larger usable dimension as the index range for random items.
    task automatic set_span(input int unsigned rows, input int unsigned cols);
        index_span = (rows > cols) ? rows : cols;
        if (index_span > MAX_DIM)
            index_span = MAX_DIM;
        if (index_span == 0)
            index_span = 1;
    endtask

    // One phase: drain, reconfigure in random order, pick idle behavior, run items.
    task automatic run_phase(
        input int unsigned rows,
        input int unsigned cols,
        input int unsigned n_items,
        input bit          squeeze
    );
        wait_drained();
        if ($urandom_range(0, 1) == 0) begin
            write_reg(REG_ROW_COUNT, CNT_W'(rows));
            write_reg(REG_COL_COUNT, CNT_W'(cols));
        end else begin
            write_reg(REG_COL_COUNT, CNT_W'(cols));
            write_reg(REG_ROW_COUNT, CNT_W'(rows));
        end
        // an index past the register list must leave everything alone
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                      CNT_W'($urandom()));
        set_span(rows, cols);
        tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
        rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
        if (squeeze) begin
            // stream without gaps into a receiver that stops for a long stretch
            tx_gap_max = 0;
            hold_off_request = HOLD_OFF_CYCLES;
        end
        repeat (n_items) send_random_access();
    endtask

    initial begin : stimulus
        int unsigned rows;
        int unsigned cols;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on a 3 x 5 matrix; the clearing pass holds off the
        // first transaction by itself.
        write_reg(REG_ROW_COUNT, 3);
        write_reg(REG_COL_COUNT, 5);
        set_span(3, 5);
        send_access(FUNC_WRITE, 0, 0, 32'hFFFF_FFFF);
        send_access(FUNC_WRITE, 2, 4, 32'h8000_0001);
        send_access(FUNC_WRITE, 1, 3, 32'h1234_5678);
        send_access(FUNC_WRITE, 1, 1, 32'h0000_0000);
        send_access(FUNC_READ, 0, 0, 0);
        send_access(FUNC_READ, 2, 4, 0);
        // first row and first column past the edge, then the largest indices
        send_access(FUNC_READ, 3, 0, 0);
        send_access(FUNC_READ, 0, 5, 0);
        send_access(FUNC_READ, CNT_W'(INDEX_TOP), CNT_W'(INDEX_TOP), 32'hFFFF_FFFF);
        send_access(FUNC_WRITE, 0, CNT_W'(INDEX_TOP), 32'hDEAD_BEEF);
        send_access(FUNC_SWAP_ROWS, 0, 2, 0);
        send_access(FUNC_READ, 0, 4, 0);
        // swap of a row with itself, then a swap reaching past the last row
        send_access(FUNC_SWAP_ROWS, 1, 1, 0);
        send_access(FUNC_SWAP_ROWS, 0, 3, 0);
        send_access(FUNC_SWAP_COLS, 4, 0, 0);
        send_access(FUNC_SWAP_COLS, 2, 2, 0);
        send_access(FUNC_SWAP_COLS, 5, 0, 0);
        // after a transpose the matrix is 5 x 3 and swaps act on new rows
        send_access(FUNC_TRANSPOSE, 0, 0, 0);
        send_access(FUNC_READ, 4, 0, 0);
        send_access(FUNC_READ, 3, 1, 0);
        send_access(FUNC_SWAP_ROWS, 4, 1, 0);
        send_access(FUNC_READ, 0, 3, 0);
        send_access(FUNC_TRANSPOSE, CNT_W'(INDEX_TOP), CNT_W'(INDEX_TOP), 32'hFFFF_FFFF);
        for (int f = FUNC_UNUSED_FIRST; f <= FUNC_UNUSED_LAST; f++)
            send_access(FUNC_W'(f), 1, 2, 32'h5A5A_A5A5);

        // Random phases over a range of shapes; the last one is drawn.
        for (int p = 0; p < N_PHASES; p++) begin
            rows = phase_rows[p];
            cols = phase_cols[p];
            if (p == N_PHASES - 1) begin
                rows = $urandom_range(1, 10);
                cols = $urandom_range(1, 10);
            end
            run_phase(rows, cols, (rows == 0 || cols == 0) ? ZERO_DIM_ITEMS : PHASE_ITEMS,
                      p == 2);
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
